@@ src/ppt_pkg.sv @@
// package: state, command and status codes and reset values of the pulse time tracker
package ppt_pkg;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_DIV,
      S_FIX,
      S_APPLY,
      S_WIN,
      S_END
   } state_type;

   typedef logic [1:0] cmd_type;
   typedef logic [2:0] status_type;

   localparam cmd_type CMD_SET_REF = 2'd0;
   localparam cmd_type CMD_CORRECT = 2'd1;
   localparam cmd_type CMD_ADVANCE = 2'd2;
   localparam cmd_type CMD_QUERY   = 2'd3;

   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_NO_REF   = 3'd1;
   localparam status_type ST_EARLY    = 3'd2;
   localparam status_type ST_LATE     = 3'd3;
   localparam status_type ST_OUT_TOL  = 3'd4;
   localparam status_type ST_IN_TOL   = 3'd5;

   localparam logic [1:0] REG_PERIOD  = 2'd0;
   localparam logic [1:0] REG_PULSE   = 2'd1;
   localparam logic [1:0] REG_RASTER  = 2'd2;
   localparam logic [1:0] REG_MAX_DEV = 2'd3;

   localparam logic [31:0] PERIOD_RESET  = 32'd1000000;
   localparam logic [31:0] PULSE_RESET   = 32'd1000;
   localparam logic [31:0] RASTER_RESET  = 32'd10000;
   localparam logic [31:0] MAX_DEV_RESET = 32'd100;

   localparam logic [31:0] DEV_NEG_LIMIT = 32'h8000_0000;
   localparam logic [31:0] DEV_POS_LIMIT = 32'h7FFF_FFFF;

endpackage

@@ src/periodic_pulse_time_tracker.sv @@
// top level: periodic pulse time tracker with bit-serial raster remainder unit
//
// Tracks the sample time of a periodic pulse. One request at a time is taken; req_stall is
// high from the transfer of a request until its result has been loaded into the output
// register. The result register is separate, so a new request is taken while an earlier
// result still waits on rsp_stall. Without a reference, every command loads its result
// from S_CALC; advance and query pass through S_CALC, S_WIN and S_END; set reference
// with a reference and correct on raster pass through S_CALC, S_DIV, S_FIX and S_APPLY.
// The next request can be taken in the cycle after the result is loaded. The S_DIV
// step is the restoring remainder unit, which takes one bit of |time - estimate|
// per cycle against a 32-bit raster. While rsp_stall holds the result register, a
// finished request waits in S_CALC, S_APPLY or S_END.
// Configuration writes are always taken (csr_ready is tied high) and must only be issued
// while the block is idle.
module periodic_pulse_time_tracker #(
   parameter int TIME_BITS = 63
) (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ppt_pkg::cmd_type         req_cmd,
   input  logic [TIME_BITS-1:0]     req_time_value,
   input  logic [31:0]              req_raster_override,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ppt_pkg::status_type      rsp_status,
   output logic [TIME_BITS-1:0]     rsp_pulse_start,
   output logic [TIME_BITS-1:0]     rsp_pulse_end,
   output logic signed [31:0]       rsp_deviation,
   output logic [TIME_BITS-1:0]     rsp_estimate,
   // register write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data
);
   import ppt_pkg::*;

   localparam int CNT_W = $clog2(TIME_BITS + 1);
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   // control state
   state_type state_ff, state_in;
   logic      est_valid_ff, est_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // configuration registers
   logic [31:0] period_ff, pulse_ff, raster_ff, max_dev_ff;

   // request and working registers
   cmd_type                cmd_ff, cmd_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [31:0]            ovr_ff, ovr_in;
   logic [TIME_BITS-1:0]   est_ff, est_in;
   logic [TIME_BITS-1:0]   a_ff, a_in;        // |time - estimate|, shifted out msb first
   logic                   a_neg_ff, a_neg_in;
   logic [31:0]            r_ff, r_in;        // effective raster
   logic [31:0]            rem_ff, rem_in;    // partial remainder
   logic [31:0]            mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [TIME_BITS:0]     next_ff, next_in;  // estimate + period, one carry bit
   logic [TIME_BITS+1:0]   end_ff, end_in;    // next + pulse length
   status_type             win_st_ff, win_st_in;

   // result register payload
   status_type             o_status_ff, o_status_in;
   logic [TIME_BITS-1:0]   o_start_ff, o_start_in;
   logic [TIME_BITS-1:0]   o_end_ff, o_end_in;
   logic [31:0]            o_dev_ff, o_dev_in;
   logic [TIME_BITS-1:0]   o_est_ff, o_est_in;

   // helpers
   logic                   out_free;
   logic [32:0]            rem_shift;
   logic [31:0]            r_sel;
   logic                   half_up;
   logic [31:0]            r_minus_rem;
   logic [31:0]            dev_val;
   logic [TIME_BITS:0]     est_plus_mag;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = o_status_ff;
   assign rsp_pulse_start = o_start_ff;
   assign rsp_pulse_end   = o_end_ff;
   assign rsp_deviation   = o_dev_ff;
   assign rsp_estimate    = o_est_ff;

   // one restoring step: bring in the next bit of the distance
   assign rem_shift = {rem_ff, a_ff[TIME_BITS-1]};

   // raster for this command; zero counts as one
   always_comb begin
      if (cmd_ff == CMD_SET_REF) begin
         r_sel = period_ff;
      end else if (ovr_ff != 32'd0) begin
         r_sel = ovr_ff;
      end else begin
         r_sel = raster_ff;
      end
      if (r_sel == 32'd0) begin
         r_sel = 32'd1;
      end
   end

   // round to nearest: remainder at or above half the raster goes to the next point
   assign half_up     = (rem_ff >= (r_ff - (r_ff >> 1)));
   assign r_minus_rem = r_ff - rem_ff;

   // deviation saturated to the signed 32-bit range
   always_comb begin
      if (neg_ff) begin
         dev_val = (mag_ff > DEV_NEG_LIMIT) ? DEV_NEG_LIMIT : (32'd0 - mag_ff);
      end else begin
         dev_val = (mag_ff > DEV_POS_LIMIT) ? DEV_POS_LIMIT : mag_ff;
      end
   end

   assign est_plus_mag = {1'b0, est_ff} + (TIME_BITS+1)'(mag_ff);

   // sequencer: next state and next values of all registers
   always_comb begin
      state_in     = state_ff;
      est_valid_in = est_valid_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      time_in      = time_ff;
      ovr_in       = ovr_ff;
      est_in       = est_ff;
      a_in         = a_ff;
      a_neg_in     = a_neg_ff;
      r_in         = r_ff;
      rem_in       = rem_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      next_in      = next_ff;
      end_in       = end_ff;
      win_st_in    = win_st_ff;
      o_status_in  = o_status_ff;
      o_start_in   = o_start_ff;
      o_end_in     = o_end_ff;
      o_dev_in     = o_dev_ff;
      o_est_in     = o_est_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               time_in  = req_time_value;
               ovr_in   = req_raster_override;
               state_in = S_CALC;
            end
         end

         S_CALC: begin
            if (!est_valid_ff) begin
               // first reference, or nothing to work against
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  o_start_in   = '0;
                  o_end_in     = '0;
                  o_dev_in     = '0;
                  if (cmd_ff == CMD_SET_REF) begin
                     o_status_in  = ST_OK;
                     est_in       = time_ff;
                     est_valid_in = 1'b1;
                     o_est_in     = time_ff;
                  end else begin
                     o_status_in  = ST_NO_REF;
                     o_est_in     = est_ff;
                  end
                  state_in = S_IDLE;
               end
            end else if (cmd_ff == CMD_SET_REF || cmd_ff == CMD_CORRECT) begin
               // distance to the estimate, then bit-serial remainder
               if (time_ff >= est_ff) begin
                  a_in     = time_ff - est_ff;
                  a_neg_in = 1'b0;
               end else begin
                  a_in     = est_ff - time_ff;
                  a_neg_in = 1'b1;
               end
               r_in     = r_sel;
               rem_in   = '0;
               cnt_in   = CNT_W'(TIME_BITS);
               state_in = S_DIV;
            end else begin
               next_in  = {1'b0, est_ff} + (TIME_BITS+1)'(period_ff);
               state_in = S_WIN;
            end
         end

         S_DIV: begin
            if (rem_shift >= {1'b0, r_ff}) begin
               rem_in = 32'(rem_shift - {1'b0, r_ff});
            end else begin
               rem_in = rem_shift[31:0];
            end
            a_in   = {a_ff[TIME_BITS-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = S_FIX;
            end
         end

         S_FIX: begin
            if (half_up) begin
               mag_in = r_minus_rem;
               neg_in = !a_neg_ff;
            end else begin
               mag_in = rem_ff;
               neg_in = a_neg_ff;
            end
            if (mag_in == 32'd0) begin
               neg_in = 1'b0;
            end
            state_in = S_APPLY;
         end

         S_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_start_in   = '0;
               o_end_in     = '0;
               o_dev_in     = dev_val;
               o_status_in  = ST_OK;
               if (cmd_ff == CMD_SET_REF) begin
                  // reference is taken in any case, a close match only warns
                  if (mag_ff <= max_dev_ff) begin
                     o_status_in = ST_IN_TOL;
                  end
                  est_in = time_ff;
               end else if (mag_ff > max_dev_ff) begin
                  o_status_in = ST_OUT_TOL;
               end else if (neg_ff) begin
                  if (TIME_BITS'(mag_ff) > est_ff) begin
                     est_in = '0;
                  end else begin
                     est_in = est_ff - TIME_BITS'(mag_ff);
                  end
               end else begin
                  est_in = est_plus_mag[TIME_BITS] ? TIME_MAX
                                                   : est_plus_mag[TIME_BITS-1:0];
               end
               o_est_in = est_in;
               state_in = S_IDLE;
            end
         end

         S_WIN: begin
            // window check against estimate and estimate + period
            if (!(est_ff < time_ff)) begin
               win_st_in = ST_EARLY;
            end else if (!({1'b0, time_ff} < next_ff)) begin
               win_st_in = ST_LATE;
            end else begin
               win_st_in = ST_OK;
            end
            end_in   = {1'b0, next_ff} + (TIME_BITS+2)'(pulse_ff);
            state_in = S_END;
         end

         S_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               o_status_in  = win_st_ff;
               o_dev_in     = '0;
               o_start_in   = '0;
               o_end_in     = '0;
               if (win_st_ff == ST_OK) begin
                  if (cmd_ff == CMD_ADVANCE) begin
                     est_in = next_ff[TIME_BITS] ? TIME_MAX : next_ff[TIME_BITS-1:0];
                  end else begin
                     o_start_in = next_ff[TIME_BITS] ? TIME_MAX : next_ff[TIME_BITS-1:0];
                     o_end_in   = (end_ff[TIME_BITS+1:TIME_BITS] != 2'b00)
                                  ? TIME_MAX : end_ff[TIME_BITS-1:0];
                  end
               end
               o_est_in = est_in;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         est_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         est_ff       <= '0;
         period_ff    <= PERIOD_RESET;
         pulse_ff     <= PULSE_RESET;
         raster_ff    <= RASTER_RESET;
         max_dev_ff   <= MAX_DEV_RESET;
      end else begin
         state_ff     <= state_in;
         est_valid_ff <= est_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         est_ff       <= est_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_PERIOD:  period_ff  <= csr_data;
               REG_PULSE:   pulse_ff   <= csr_data;
               REG_RASTER:  raster_ff  <= csr_data;
               REG_MAX_DEV: max_dev_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      time_ff     <= time_in;
      ovr_ff      <= ovr_in;
      a_ff        <= a_in;
      a_neg_ff    <= a_neg_in;
      r_ff        <= r_in;
      rem_ff      <= rem_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      next_ff     <= next_in;
      end_ff      <= end_in;
      win_st_ff   <= win_st_in;
      o_status_ff <= o_status_in;
      o_start_ff  <= o_start_in;
      o_end_ff    <= o_end_in;
      o_dev_ff    <= o_dev_in;
      o_est_ff    <= o_est_in;
   end

`ifndef SYNTHESIS
   // partial remainder always stays below the raster while dividing
   a_rem_below_raster: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < r_ff))
      else $error("partial remainder not below raster");

   // estimate cannot move while the remainder unit runs
   a_est_stable_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |=> $stable(est_ff))
      else $error("estimate changed during division");

   // once a reference exists it is never lost
   a_ref_kept: assert property (@(posedge clock) disable iff (reset)
      est_valid_ff |=> est_valid_ff)
      else $error("reference lost");

   // a result only appears as a sequence ends
   a_rsp_from_seq: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !$past(reset)) ##1 rsp_valid_ff |->
         ($past(state_ff) == S_CALC || $past(state_ff) == S_APPLY
          || $past(state_ff) == S_END))
      else $error("result without a finished request");
`endif

endmodule
